// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk with reset rst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every rising edge outside reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mma_pkg.sv -----
// ---------------------------------------------------------------------------
// mma_pkg
// status codes, defaults and channel decode helpers for the midi assembler
// ---------------------------------------------------------------------------
`default_nettype none

package mma_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 64;

    localparam logic [7:0] ST_SYSEX_START = 8'hf0;
    localparam logic [7:0] ST_MTC_QFRAME  = 8'hf1;
    localparam logic [7:0] ST_SONG_POS    = 8'hf2;
    localparam logic [7:0] ST_SONG_SEL    = 8'hf3;
    localparam logic [7:0] ST_UNDEF_F4    = 8'hf4;
    localparam logic [7:0] ST_SYSEX_END   = 8'hf7;
    localparam logic [7:0] ST_RESET       = 8'hff;

    localparam logic [3:0] HI_NOTE_OFF    = 4'h8;
    localparam logic [3:0] HI_NOTE_ON     = 4'h9;
    localparam logic [3:0] HI_POLY_PRESS  = 4'ha;
    localparam logic [3:0] HI_CONTROL     = 4'hb;
    localparam logic [3:0] HI_PROGRAM     = 4'hc;
    localparam logic [3:0] HI_CHAN_PRESS  = 4'hd;
    localparam logic [3:0] HI_PITCH_BEND  = 4'he;

    function automatic logic is_three_byte_channel(input logic [7:0] s);
        logic [3:0] hi;
        hi = s[7:4];
        return (hi == HI_NOTE_OFF) || (hi == HI_NOTE_ON) || (hi == HI_POLY_PRESS) ||
               (hi == HI_CONTROL) || (hi == HI_PITCH_BEND);
    endfunction

    function automatic logic is_two_byte_channel(input logic [7:0] s);
        logic [3:0] hi;
        hi = s[7:4];
        return (hi == HI_PROGRAM) || (hi == HI_CHAN_PRESS);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/midi_message_assembler.sv -----
// sequence: each accepted byte is evaluated in S_EVAL; a byte that completes no message
// returns the block to S_IDLE, while a completed message is emitted byte by byte, each
// byte going through S_READ (one buffer read) and S_LOAD, which holds while m_tvalid is
// high and m_tready low; no new input byte is taken until that message has been emitted
// reset: sequencer, length, running status and output valid clear at once; buffer
// contents stay undefined and need no clearing pass
// ---------------------------------------------------------------------------
// midi_message_assembler
// collects raw midi bytes into complete messages with running status and
// streams each message out byte by byte, tlast on the final byte
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module midi_message_assembler
    import mma_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] midi_byte

    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] msg_byte
    output logic            m_tlast    // msg_last
);

    localparam int LW = $clog2(BUFFER_DEPTH + 1);   // length, 0..depth
    localparam int AW = $clog2(BUFFER_DEPTH);       // buffer address

    localparam logic [LW-1:0] LEN_FULL = LW'(BUFFER_DEPTH);
    localparam logic [LW-1:0] LEN_ONE  = LW'(1);
    localparam logic [LW-1:0] LEN_TWO  = LW'(2);
    localparam logic [LW-1:0] LEN_THREE = LW'(3);

    typedef enum logic [1:0] {
        S_IDLE,   // waiting for an input byte
        S_EVAL,   // update buffer, decide on completion
        S_READ,   // buffer read in flight
        S_LOAD    // move byte into the output register
    } state_t;

    // sequencer and control state
    state_t        state_reg,  state_next;
    logic [LW-1:0] len_reg,    len_next;
    logic [7:0]    rs_reg,     rs_next;      // running status
    logic [7:0]    first_reg,  first_next;   // buffer entry zero lives here
    logic [7:0]    byte_reg,   byte_next;    // byte under evaluation
    logic [LW-1:0] cnt_reg,    cnt_next;     // bytes to emit
    logic [AW-1:0] idx_reg,    idx_next;     // emit position, also the buffer read address
    logic          mvalid_reg, mvalid_next;
    logic [7:0]    mbyte_reg,  mbyte_next;
    logic          mlast_reg,  mlast_next;

    // message buffer
    logic [7:0]    mem [BUFFER_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    // evaluation terms
    logic          ovf;
    logic [LW-1:0] len_a, len_b, len_c;
    logic [7:0]    first_a, first_b, first_c;
    logic [7:0]    rs_a;
    logic          restart;
    logic          sys_done, chan_done, fix_data;
    logic          emit_last;
    logic          can_load;

    always_comb
    begin
        // byte joins the buffer, or restarts it when full
        ovf     = (len_reg == LEN_FULL);
        len_a   = ovf ? LEN_ONE : len_reg + LEN_ONE;
        first_a = (ovf || (len_reg == '0)) ? byte_reg : first_reg;
        rs_a    = ovf ? 8'h00 : rs_reg;

        // a status byte after the first restarts, except sysex end
        restart = (len_a > LEN_ONE) && byte_reg[7] &&
                  !((first_a == ST_SYSEX_START) && (byte_reg == ST_SYSEX_END));
        first_b = restart ? byte_reg : first_a;
        len_b   = restart ? LEN_ONE : len_a;

        // system messages
        sys_done = ((first_b > ST_UNDEF_F4) && (first_b < ST_RESET)) ||
                   (((first_b == ST_MTC_QFRAME) || (first_b == ST_SONG_SEL)) &&
                    (len_b == LEN_TWO)) ||
                   ((first_b == ST_SONG_POS) && (len_b == LEN_THREE)) ||
                   ((first_b == ST_SYSEX_START) && (byte_reg == ST_SYSEX_END));

        // lone data byte: prepend running status
        fix_data = !sys_done && !first_b[7];
        first_c  = fix_data ? rs_a : first_b;
        len_c    = fix_data ? LEN_TWO : len_b;

        chan_done = !sys_done &&
                    ((is_three_byte_channel(first_c) && (len_c == LEN_THREE)) ||
                     (is_two_byte_channel(first_c) && (len_c == LEN_TWO)));

        // at most one buffer write per byte; entry zero is held in first_reg
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = byte_reg;
        if (state_reg == S_EVAL)
        begin
            if (fix_data)
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(1);
                wr_data = first_b;
            end
            else if (!ovf && (len_reg != '0))
            begin
                wr_en   = 1'b1;
                wr_addr = len_reg[AW-1:0];
            end
        end

        emit_last = ({1'b0, idx_reg} == LW'(cnt_reg - LEN_ONE));
        can_load  = !mvalid_reg || m_tready;

        state_next  = state_reg;
        len_next    = len_reg;
        rs_next     = rs_reg;
        first_next  = first_reg;
        byte_next   = byte_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        mbyte_next  = mbyte_reg;
        mlast_next  = mlast_reg;
        mvalid_next = mvalid_reg;
        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_next  = s_tdata;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                first_next = first_c;
                rs_next    = chan_done ? first_c : rs_a;
                if (sys_done || chan_done)
                begin
                    cnt_next   = sys_done ? len_b : len_c;
                    idx_next   = '0;
                    len_next   = '0;
                    state_next = S_READ;
                end
                else
                begin
                    len_next   = len_c;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (can_load)
                begin
                    mbyte_next  = (idx_reg == '0) ? first_reg : rd_data_reg;
                    mlast_next  = emit_last;
                    mvalid_next = 1'b1;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            rs_reg     <= '0;
            first_reg  <= '0;
            byte_reg   <= '0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            mvalid_reg <= 1'b0;
            mbyte_reg  <= '0;
            mlast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            rs_reg     <= rs_next;
            first_reg  <= first_next;
            byte_reg   <= byte_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            mvalid_reg <= mvalid_next;
            mbyte_reg  <= mbyte_next;
            mlast_reg  <= mlast_next;
        end
    end

    // buffer: one write port, one registered read port on the emit counter
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[idx_reg];
    end

    // input is taken only in S_IDLE, not while evaluating or emitting
    assign s_tready = (state_reg == S_IDLE);

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mbyte_reg;
    assign m_tlast  = mlast_reg;

    `ASSERT_ALWAYS(a_len_bound, len_reg <= LEN_FULL, "buffer length beyond depth")
    `ASSERT_IMPLY(a_emit_len_clear, (state_reg == S_READ) || (state_reg == S_LOAD), len_reg == '0, "length not cleared while emitting")
    `ASSERT_IMPLY(a_emit_idx, (state_reg == S_READ) || (state_reg == S_LOAD), ({1'b0, idx_reg} < cnt_reg) && (cnt_reg != '0), "emit index out of message")
    `ASSERT_IMPLY(a_last_ends, (state_reg == S_LOAD) && can_load && emit_last, ##1 (state_reg == S_IDLE) && m_tlast, "last byte did not end the message")

endmodule

`default_nettype wire

// ----- bench/midi_message_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// midi_message_checker
// watches both stream channels of the midi assembler, rebuilds each completed
// message from the accepted input bytes and compares every output transfer
// ---------------------------------------------------------------------------
module midi_message_checker
    import mma_pkg::*;
#(
    parameter int DEPTH = DEFAULT_BUFFER_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] midi_byte

    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,    // [7:0] msg_byte
    input  logic       m_tlast,    // msg_last

    output int         fail_count,
    output int         outstanding
);

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } msg_beat_t;

    msg_beat_t   pending_beats[$];
    logic [7:0]  msg_buf [DEPTH];
    int unsigned buf_len;
    logic [7:0]  run_status;

    // total length of a channel message, 0 for anything else
    function automatic int unsigned channel_length(input logic [7:0] status);
        case (status[7:4])
            HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_PRESS, HI_CONTROL, HI_PITCH_BEND: return 3;
            HI_PROGRAM, HI_CHAN_PRESS: return 2;
            default: return 0;
        endcase
    endfunction

    task automatic absorb_byte(input logic [7:0] value);
        logic [7:0]  head;
        logic [7:0]  tail;
        int unsigned done_len;
        int unsigned i;
        msg_beat_t   beat;

        if (buf_len < DEPTH)
        begin
            msg_buf[buf_len] = value;
            buf_len++;
        end
        else
        begin
            // full buffer: restart with this byte, forget running status
            msg_buf[0] = value;
            buf_len    = 1;
            run_status = '0;
        end

        done_len = 0;
        head     = msg_buf[0];
        tail     = msg_buf[buf_len - 1];

        // status after the first byte restarts, except the end of a sysex
        if (buf_len > 1 && tail[7] && !(head == ST_SYSEX_START && tail == ST_SYSEX_END))
        begin
            msg_buf[0] = tail;
            buf_len    = 1;
            head       = tail;
        end

        if (head > ST_UNDEF_F4 && head < ST_RESET)
            done_len = 1;
        else if ((head == ST_MTC_QFRAME || head == ST_SONG_SEL) && buf_len == 2)
            done_len = 2;
        else if (head == ST_SONG_POS && buf_len == 3)
            done_len = 3;
        else if (head == ST_SYSEX_START && msg_buf[buf_len - 1] == ST_SYSEX_END)
            done_len = buf_len;
        else
        begin
            // lone data byte goes behind the running status, whatever it holds
            if (!head[7])
            begin
                msg_buf[1] = head;
                msg_buf[0] = run_status;
                buf_len    = 2;
                head       = run_status;
            end
            if (channel_length(head) != 0 && channel_length(head) == buf_len)
            begin
                run_status = head;
                done_len   = buf_len;
            end
        end

        if (done_len != 0)
        begin
            for (i = 0; i < done_len; i++)
            begin
                beat.data = msg_buf[i];
                beat.last = (i + 1 == done_len);
                pending_beats.push_back(beat);
            end
            buf_len = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        msg_beat_t beat;
        if (!rst_n)
        begin
            pending_beats.delete();
            buf_len     = 0;
            run_status  = '0;
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata);

            if (m_tvalid && m_tready)
            begin
                if (pending_beats.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected transfer, expected none, got byte %02h last %0b",
                                 $time, m_tdata, m_tlast);
                end
                else
                begin
                    beat = pending_beats.pop_front();
                    if (m_tdata !== beat.data)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: msg_byte mismatch, expected %02h, got %02h",
                                     $time, beat.data, m_tdata);
                    end
                    if (m_tlast !== beat.last)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: msg_last mismatch, expected %0b, got %0b",
                                     $time, beat.last, m_tlast);
                    end
                end
            end

            outstanding <= pending_beats.size();
        end
    end

endmodule

// ----- bench/midi_message_assembler_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// midi_message_assembler_tb
// feeds raw midi bytes through the assembler: a directed opening over system
// and three channel message kinds and corners, then random streams under
// several idling patterns; the checker predicts and compares each transfer
// ---------------------------------------------------------------------------
module midi_message_assembler_tb;
    import mma_pkg::*;

    localparam int      DEPTH         = DEFAULT_BUFFER_DEPTH;
    localparam int      PHASE_BYTES   = 12;
    localparam longint  RUN_LIMIT_NS  = 8_000_000;

    // ends of the single-byte realtime range
    localparam logic [7:0] RT_FIRST = 8'hf5;
    localparam logic [7:0] RT_LAST  = 8'hfe;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;     // [7:0] midi_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] msg_byte
    logic       m_tlast;           // msg_last

    int fail_count;
    int outstanding;
    int bytes_sent = 0;
    int idle_pct   = 0;            // chance per byte slot that the sender holds off
    int stall_pct  = 0;            // chance per cycle that the receiver drops tready

    // directed opening: system and three channel kinds, range ends, odd corners
    logic [7:0] opening [$] = '{
        8'h05, 8'h06,                              // data before any status ever seen
        RT_FIRST, RT_LAST,                         // single-byte messages
        ST_MTC_QFRAME, 8'h00,
        ST_SONG_SEL, 8'h7f,
        ST_SONG_POS, 8'h01, 8'h7f,
        {HI_NOTE_ON, 4'ha}, 8'h3c, 8'h7f,
        8'h40, 8'h00,                              // reuses the note-on status
        {HI_PROGRAM, 4'h5}, 8'h12,
        8'h7f,                                     // running status on a two-byte message
        ST_SYSEX_START, 8'h01, ST_SYSEX_END,
        ST_SYSEX_END,                              // end of sysex with no start
        ST_UNDEF_F4, 8'h12,
        ST_RESET,                                  // status in the middle of a message
        {HI_PITCH_BEND, 4'h3}, 8'h00, 8'h7f
    };

    midi_message_assembler #(
        .BUFFER_DEPTH (DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    midi_message_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: ready drops at random according to the current phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // one input transfer, with random hold-off before the byte is offered
    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_data(input int count);
        logic [7:0] value;
        repeat (count)
        begin
            value = 8'($urandom_range(127));
            send_byte(value);
        end
    endtask

    // sender stays quiet until every predicted transfer has come out
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // one random message, mostly well formed, sometimes broken or pure noise
    task automatic send_random_sequence();
        int         roll;
        logic [3:0] hi;
        logic [3:0] chan;
        logic [7:0] value;

        roll = $urandom_range(99);
        hi   = 4'($urandom_range(14, 8));
        chan = 4'($urandom_range(15));
        if (roll < 30)
        begin
            // channel message with a fresh status
            send_byte({hi, chan});
            send_data((hi == HI_PROGRAM || hi == HI_CHAN_PRESS) ? 1 : 2);
        end
        else if (roll < 45)
        begin
            // data only, leaning on running status
            send_data($urandom_range(2, 1));
        end
        else if (roll < 55)
        begin
            case ($urandom_range(2))
                0:       begin send_byte(ST_MTC_QFRAME); send_data(1); end
                1:       begin send_byte(ST_SONG_SEL);   send_data(1); end
                default: begin send_byte(ST_SONG_POS);   send_data(2); end
            endcase
        end
        else if (roll < 63)
        begin
            value = 8'($urandom_range(RT_LAST, RT_FIRST));
            send_byte(value);
        end
        else if (roll < 73)
        begin
            send_byte(ST_SYSEX_START);
            send_data($urandom_range(8));
            send_byte(ST_SYSEX_END);
        end
        else if (roll < 83)
        begin
            // channel message, usually cut short by another status byte
            send_byte({hi, chan});
            send_data($urandom_range(1));
            value = 8'($urandom_range(255, 128));
            send_byte(value);
        end
        else if (roll < 90)
        begin
            // status that never completes, followed by loose data
            send_byte($urandom_range(1) ? ST_UNDEF_F4 : ST_RESET);
            send_data($urandom_range(4));
        end
        else
        begin
            repeat ($urandom_range(3, 1))
            begin
                value = 8'($urandom_range(255));
                send_byte(value);
            end
        end
    endtask

    initial
    begin
        int phase;
        int target;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening[i])
            send_byte(opening[i]);
        wait_for_drain();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 55; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase

            if (phase == 1)
            begin
                // fill the buffer to the brim, then overflow it with a data byte
                case ($urandom_range(2))
                    0:       send_byte(ST_SYSEX_START);
                    1:       send_byte(ST_UNDEF_F4);
                    default: send_byte(ST_RESET);
                endcase
                send_data(DEPTH - 1);
                send_data(1);
            end
            if (phase == 2)
            begin
                // longest message the buffer can hold, drained under heavy stalls
                send_byte(ST_SYSEX_START);
                send_data(DEPTH - 2);
                send_byte(ST_SYSEX_END);
            end

            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
                send_random_sequence();
            wait_for_drain();
        end

        // let any stray output show up before the verdict
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- midi_message_assembler.f -----
+incdir+hdl
hdl/mma_pkg.sv
hdl/midi_message_assembler.sv
bench/midi_message_checker.sv
bench/midi_message_assembler_tb.sv
